// ===== src/cilc_pkg.sv =====
// Shared types and codes for the C integer literal classifier.
// No dependencies.
package cilc_pkg;

    localparam int RESULT_VALUE_BITS = 64;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_OCT,
        BASE_HEX,
        BASE_BIN
    } base_t;

    typedef enum logic [1:0] {
        PH_START,
        PH_ZERO,
        PH_DIGITS,
        PH_SUFFIX
    } phase_t;

    typedef enum logic [3:0] {
        SF_NONE,
        SF_U,
        SF_L1,
        SF_L1UP,
        SF_LL,
        SF_ULO,
        SF_UUP,
        SF_DONE,
        SF_DEAD
    } suffix_t;

    localparam logic [1:0] TYPE_INT32  = 2'd0;
    localparam logic [1:0] TYPE_UINT32 = 2'd1;
    localparam logic [1:0] TYPE_INT64  = 2'd2;
    localparam logic [1:0] TYPE_UINT64 = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NOT_INT  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [RESULT_VALUE_BITS-1:0] literal_value;
        logic [1:0]                   type_code;
        logic [1:0]                   status;
    } result_t;

endpackage

// ===== src/c_integer_literal_classifier_top.sv =====
// A last character's result is registered once the result register is free.
// Throughput: one character item per cycle; a last one waits while the output stalls.
// Characters without tlast give no result; the scanner returns to token start
// after each last character.
// Reset: rst_n asynchronous, active low; clears scan state and valid flags.
module c_integer_literal_classifier_top
    import cilc_pkg::*;
#(
    parameter int VALUE_BITS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [63:0] literal_value, [65:64] type_code,
                                   // [67:66] status, [71:68] zero
);

    logic    res_valid;
    result_t res;
    logic    out_free;
    result_t out_res;

    cilc_scan #(
        .VALUE_BITS (VALUE_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_char   (s_tdata),
        .in_last   (s_tlast),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    cilc_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {4'b0000, out_res.status, out_res.type_code, out_res.literal_value};

endmodule

// ===== src/cilc_scan.sv =====
// Input register, token scan state, result decode: one char per unstalled cycle.
// Depends on cilc_pkg.
module cilc_scan
    import cilc_pkg::*;
#(
    parameter int VALUE_BITS = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       in_last,
    input  logic       out_free,
    output logic       res_valid,
    output result_t    res
);

    localparam int WIDE = VALUE_BITS + 4;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UL    = 8'h4C;
    localparam logic [7:0] CH_UU    = 8'h55;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LL    = 8'h6C;
    localparam logic [7:0] CH_LU    = 8'h75;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [4:0] NO_DIGIT = 5'd16;

    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [4:0] d;
        d = NO_DIGIT;
        if (c >= CH_0 && c <= CH_9)
        begin
            d = 5'(c - CH_0);
        end
        else if (c >= CH_LA && c <= CH_LF)
        begin
            d = 5'(c - CH_LA) + 5'd10;
        end
        else if (c >= CH_UA && c <= CH_UF)
        begin
            d = 5'(c - CH_UA) + 5'd10;
        end
        return d;
    endfunction

    function automatic logic [4:0] radix_of(input base_t b);
        logic [4:0] r;
        unique case (b)
            BASE_DEC: r = 5'd10;
            BASE_OCT: r = 5'd8;
            BASE_HEX: r = 5'd16;
            BASE_BIN: r = 5'd2;
        endcase
        return r;
    endfunction

    function automatic suffix_t suffix_next(input suffix_t s, input logic [7:0] c);
        logic    isu;
        suffix_t n;
        isu = (c == CH_LU) || (c == CH_UU);
        n   = SF_DEAD;
        unique case (s)
            SF_NONE:
            begin
                if (isu)              n = SF_U;
                else if (c == CH_LL)  n = SF_L1;
                else if (c == CH_UL)  n = SF_L1UP;
            end
            SF_U:
            begin
                if (c == CH_LL)       n = SF_ULO;
                else if (c == CH_UL)  n = SF_UUP;
            end
            SF_L1:
            begin
                if (c == CH_LL)       n = SF_LL;
                else if (isu)         n = SF_DONE;
            end
            SF_L1UP:
            begin
                if (c == CH_UL)       n = SF_LL;
                else if (isu)         n = SF_DONE;
            end
            SF_LL:
            begin
                if (isu)              n = SF_DONE;
            end
            SF_ULO:
            begin
                if (c == CH_LL)       n = SF_DONE;
            end
            SF_UUP:
            begin
                if (c == CH_UL)       n = SF_DONE;
            end
            default:
            begin
                n = SF_DEAD;
            end
        endcase
        return n;
    endfunction

    function automatic logic [1:0] pick_type(input suffix_t s, input base_t b,
                                             input logic [63:0] v);
        logic       u;
        logic       l;
        logic [1:0] t;
        u = (s == SF_U) || (s == SF_ULO) || (s == SF_UUP) || (s == SF_DONE);
        l = (s != SF_NONE) && (s != SF_U) && (s != SF_DEAD);
        priority if (l && u)
            t = TYPE_UINT64;
        else if (b == BASE_DEC && l)
            t = TYPE_INT64;
        else if (u)
            t = (|v[63:32]) ? TYPE_UINT64 : TYPE_UINT32;
        else if (b == BASE_DEC)
            t = (|v[63:31]) ? TYPE_INT64 : TYPE_INT32;
        else if (l)
            t = v[63] ? TYPE_UINT64 : TYPE_INT64;
        else if (v[63])
            t = TYPE_UINT64;
        else if (|v[62:32])
            t = TYPE_INT64;
        else if (v[31])
            t = TYPE_UINT32;
        else
            t = TYPE_INT32;
        return t;
    endfunction

    // input stage
    logic       item_valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       fire;

    // scan state
    logic [VALUE_BITS-1:0] acc_reg,    acc_next;
    base_t                 base_reg,   base_next;
    phase_t                phase_reg,  phase_next;
    suffix_t               suffix_reg, suffix_next_s;
    logic                  seen_reg,   seen_next;
    logic                  ovf_reg,    ovf_next;

    base_t            eff_base;
    logic [4:0]       dv;
    logic             digit_ok;
    logic [WIDE-1:0]  acc_wide;
    logic [WIDE-1:0]  mul;
    logic [WIDE-1:0]  sum;
    logic             ovf_step;
    logic             take_digit;
    logic             to_suffix;

    assign fire     = item_valid_reg && (!last_reg || out_free);
    assign in_ready = !item_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= in_char;
            last_reg <= in_last;
        end
    end

    // digit datapath: acc * radix + digit, with carry-out as overflow
    always_comb
    begin
        eff_base = (phase_reg == PH_START) ? BASE_DEC : base_reg;
        dv       = digit_value(char_reg);
        digit_ok = dv < radix_of(eff_base);
        acc_wide = WIDE'(acc_reg);
        unique case (eff_base)
            BASE_DEC: mul = (acc_wide << 3) + (acc_wide << 1);
            BASE_OCT: mul = acc_wide << 3;
            BASE_HEX: mul = acc_wide << 4;
            BASE_BIN: mul = acc_wide << 1;
        endcase
        sum      = mul + WIDE'(dv);
        ovf_step = |sum[WIDE-1:VALUE_BITS];
    end

    // next state
    always_comb
    begin
        acc_next      = acc_reg;
        base_next     = base_reg;
        phase_next    = phase_reg;
        suffix_next_s = suffix_reg;
        seen_next     = seen_reg;
        ovf_next      = ovf_reg;
        take_digit    = 1'b0;
        to_suffix     = 1'b0;
        unique case (phase_reg)
            PH_START:
            begin
                if (char_reg == CH_0)
                begin
                    base_next  = BASE_OCT;
                    acc_next   = '0;
                    seen_next  = 1'b1;
                    phase_next = PH_ZERO;
                end
                else
                begin
                    base_next = BASE_DEC;
                    if (digit_ok)
                    begin
                        take_digit = 1'b1;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        to_suffix = 1'b1;
                    end
                end
            end
            PH_ZERO:
            begin
                if (char_reg == CH_LX || char_reg == CH_UX)
                begin
                    base_next  = BASE_HEX;
                    seen_next  = 1'b0;
                    phase_next = PH_DIGITS;
                end
                else if (char_reg == CH_LB || char_reg == CH_UB)
                begin
                    base_next  = BASE_BIN;
                    seen_next  = 1'b0;
                    phase_next = PH_DIGITS;
                end
                else if (digit_ok)
                begin
                    take_digit = 1'b1;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    to_suffix = 1'b1;
                end
            end
            PH_DIGITS:
            begin
                if (digit_ok)
                begin
                    take_digit = 1'b1;
                end
                else
                begin
                    to_suffix = 1'b1;
                end
            end
            PH_SUFFIX:
            begin
                to_suffix = 1'b1;
            end
        endcase
        if (take_digit)
        begin
            acc_next  = sum[VALUE_BITS-1:0];
            ovf_next  = ovf_reg || ovf_step;
            seen_next = 1'b1;
        end
        if (to_suffix)
        begin
            suffix_next_s = suffix_next(suffix_reg, char_reg);
            phase_next    = PH_SUFFIX;
        end
    end

    // result decode
    always_comb
    begin
        res_valid = fire && last_reg;
        if (!seen_next || suffix_next_s == SF_DEAD)
        begin
            res.literal_value = '0;
            res.type_code     = TYPE_INT32;
            res.status        = STATUS_NOT_INT;
        end
        else if (ovf_next)
        begin
            res.literal_value = RESULT_VALUE_BITS'(acc_next);
            res.type_code     = TYPE_UINT64;
            res.status        = STATUS_OVERFLOW;
        end
        else
        begin
            res.literal_value = RESULT_VALUE_BITS'(acc_next);
            res.type_code     = pick_type(suffix_next_s, base_next,
                                          RESULT_VALUE_BITS'(acc_next));
            res.status        = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            base_reg   <= BASE_DEC;
            phase_reg  <= PH_START;
            suffix_reg <= SF_NONE;
            seen_reg   <= 1'b0;
            ovf_reg    <= 1'b0;
        end
        else if (fire && last_reg)
        begin
            acc_reg    <= '0;
            base_reg   <= BASE_DEC;
            phase_reg  <= PH_START;
            suffix_reg <= SF_NONE;
            seen_reg   <= 1'b0;
            ovf_reg    <= 1'b0;
        end
        else if (fire)
        begin
            acc_reg    <= acc_next;
            base_reg   <= base_next;
            phase_reg  <= phase_next;
            suffix_reg <= suffix_next_s;
            seen_reg   <= seen_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

// ===== src/cilc_out.sv =====
// Result register and output handshake.
// Depends on cilc_pkg.
module cilc_out
    import cilc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_valid,
    input  result_t res,
    output logic    out_free,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg;
    result_t res_reg;

    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

// ===== src/cilc_checker.sv =====
// Port-level checks for the C integer literal classifier, bound to the top level.
// Depends on cilc_pkg and c_integer_literal_classifier_top.
module cilc_checker
    import cilc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_not_int_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[67:66] == STATUS_NOT_INT |->
            m_tdata[63:0] == 64'd0 && m_tdata[65:64] == TYPE_INT32)
        else $error("not-integer result carries value or type");

    a_ovf_type: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[67:66] == STATUS_OVERFLOW |-> m_tdata[65:64] == TYPE_UINT64)
        else $error("overflow result not typed uint64");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[67:66] != 2'd3 && m_tdata[71:68] == 4'd0)
        else $error("bad status code or padding");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

bind c_integer_literal_classifier_top cilc_checker u_cilc_checker (.*);
